// ===== rtl/dms_pkg.sv =====
package dms_pkg;

  localparam int BUTTON_COUNT = 3;
  localparam int COUNT_W = 16;
  localparam int CHAR_W = 8;
  localparam int MODE_W = 2;
  localparam int DIR_W = 2;
  localparam int LEVEL_W = 4;
  localparam int WIND_W = 5;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_WIND_DEFAULT = 5;

  localparam logic [COUNT_W-1:0] DEBOUNCE_RST = COUNT_W'(50);
  localparam logic [MODE_W-1:0] DEFAULT_RAIN_MODE_RST = MODE_W'(0);

  // button positions in the raw and stable vectors
  localparam int BTN_RAIN = 0;
  localparam int BTN_DIRECTION = 1;
  localparam int BTN_INTENSITY = 2;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_CHAR = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_MODE = 1'd1;

  localparam logic [MODE_W-1:0] MODE_RAIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RIPPLES = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CALM = 2'd2;

  localparam logic [DIR_W-1:0] DIR_OFF = 2'd0;
  localparam logic [DIR_W-1:0] DIR_LEFT = 2'd1;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_RAIN = 8'h72;       // 'r'
  localparam logic [CHAR_W-1:0] CHAR_WIND = 8'h77;       // 'w'
  localparam logic [CHAR_W-1:0] CHAR_INTENSITY = 8'h69;  // 'i'
  localparam logic [CHAR_W-1:0] CHAR_HELP = 8'h3F;       // '?'

  typedef struct packed {
    logic rain;
    logic direction;
    logic intensity;
  } press_t;

endpackage

// ===== rtl/dms_item_if.sv =====
interface dms_item_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic                        raw_rain_button;
  logic                        raw_direction_button;
  logic                        raw_intensity_button;
  logic [dms_pkg::CHAR_W-1:0]  char_code;

  modport source (
    output valid, req_type, raw_rain_button, raw_direction_button,
           raw_intensity_button, char_code,
    input  ready
  );
  modport sink (
    input  valid, req_type, raw_rain_button, raw_direction_button,
           raw_intensity_button, char_code,
    output ready
  );
endinterface

// ===== rtl/dms_result_if.sv =====
interface dms_result_if;
  logic                               valid;
  logic                               ready;
  logic [dms_pkg::MODE_W-1:0]         rain_mode;
  logic [dms_pkg::DIR_W-1:0]          wind_direction;
  logic [dms_pkg::LEVEL_W-1:0]        wind_level;
  logic                               rain_on;
  logic                               ripples_on;
  logic signed [dms_pkg::WIND_W-1:0]  wind_value;
  logic                               status_changed;
  logic                               help_requested;

  modport source (
    output valid, rain_mode, wind_direction, wind_level, rain_on, ripples_on,
           wind_value, status_changed, help_requested,
    input  ready
  );
  modport sink (
    input  valid, rain_mode, wind_direction, wind_level, rain_on, ripples_on,
           wind_value, status_changed, help_requested,
    output ready
  );
endinterface

// ===== rtl/dms_cfg_if.sv =====
interface dms_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [dms_pkg::CFG_INDEX_W-1:0]   index;
  logic [dms_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/debounced_mode_selector.sv =====
// path: an accepted item passes through the input register and then the result register
// throughput: one item per cycle while results are taken; a waiting result holds the
//   input register, which then takes one more item only while it is empty; the
//   settings update as an item leaves the input register
// reset (rst, synchronous): buttons released with counters saturated, rain mode 0,
//   wind off, intensity 1, debounce 50 ticks
module debounced_mode_selector #(
  parameter int MAX_WIND = dms_pkg::MAX_WIND_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  dms_item_if.sink      item,
  dms_result_if.source  result,
  dms_cfg_if.sink       cfg
);

  localparam logic [dms_pkg::LEVEL_W-1:0] LEVEL_MAX = dms_pkg::LEVEL_W'(MAX_WIND);

  // configuration
  logic [dms_pkg::COUNT_W-1:0] debounce_ticks;

  assign cfg.ready = 1'b1;

  // the default rain mode only acts at reset, and reset also restores it,
  // so a write to it is taken and has no visible effect
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= dms_pkg::DEBOUNCE_RST;
    end else if (cfg.valid && cfg.index == dms_pkg::CFG_DEBOUNCE) begin
      debounce_ticks <= cfg.data;
    end
  end

  // input register
  logic                       s1_valid;
  logic                       s1_req_type;
  logic [dms_pkg::BUTTON_COUNT-1:0] s1_raw;
  logic [dms_pkg::CHAR_W-1:0] s1_char;
  logic                       s1_advance;

  assign s1_advance = s1_valid && (!result.valid || result.ready);
  assign item.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_req_type <= item.req_type;
      s1_raw[dms_pkg::BTN_RAIN] <= item.raw_rain_button;
      s1_raw[dms_pkg::BTN_DIRECTION] <= item.raw_direction_button;
      s1_raw[dms_pkg::BTN_INTENSITY] <= item.raw_intensity_button;
      s1_char <= item.char_code;
    end
  end

  // button debounce, only ticks move it
  dms_pkg::press_t press;

  dms_debounce u_debounce (
    .clk            (clk),
    .rst            (rst),
    .en             (s1_advance && s1_req_type == dms_pkg::REQ_TICK),
    .raw            (s1_raw),
    .debounce_ticks (debounce_ticks),
    .press          (press)
  );

  // settings
  logic [dms_pkg::MODE_W-1:0]  mode;
  logic [dms_pkg::DIR_W-1:0]   direction;
  logic [dms_pkg::LEVEL_W-1:0] level;
  logic [dms_pkg::MODE_W-1:0]  mode_next;
  logic [dms_pkg::DIR_W-1:0]   direction_next;
  logic [dms_pkg::LEVEL_W-1:0] level_next;
  logic                        step_mode;
  logic                        step_direction;
  logic                        step_level;
  logic                        help;
  logic signed [dms_pkg::WIND_W-1:0] wind_next;

  always_comb begin
    step_mode = 1'b0;
    step_direction = 1'b0;
    step_level = 1'b0;
    help = 1'b0;
    if (s1_req_type == dms_pkg::REQ_TICK) begin
      step_mode = press.rain;
      step_direction = press.direction;
      step_level = press.intensity;
    end else begin
      case (s1_char)
        dms_pkg::CHAR_RAIN:      step_mode = 1'b1;
        dms_pkg::CHAR_WIND:      step_direction = 1'b1;
        dms_pkg::CHAR_INTENSITY: step_level = 1'b1;
        dms_pkg::CHAR_HELP:      help = 1'b1;
        default: ;
      endcase
    end

    mode_next = mode;
    if (step_mode) begin
      mode_next = (mode >= dms_pkg::MODE_CALM) ? dms_pkg::MODE_RAIN : mode + 1'b1;
    end
    direction_next = direction;
    if (step_direction) begin
      direction_next = (direction >= dms_pkg::DIR_RIGHT) ? dms_pkg::DIR_OFF
                                                          : direction + 1'b1;
    end
    level_next = level;
    if (step_level) begin
      level_next = (level >= LEVEL_MAX) ? dms_pkg::LEVEL_W'(1) : level + 1'b1;
    end

    case (direction_next)
      dms_pkg::DIR_LEFT:  wind_next = -$signed({1'b0, level_next});
      dms_pkg::DIR_RIGHT: wind_next = $signed({1'b0, level_next});
      default:            wind_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= dms_pkg::DEFAULT_RAIN_MODE_RST;
      direction <= dms_pkg::DIR_OFF;
      level <= dms_pkg::LEVEL_W'(1);
    end else if (s1_advance) begin
      mode <= mode_next;
      direction <= direction_next;
      level <= level_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      result.rain_mode <= mode_next;
      result.wind_direction <= direction_next;
      result.wind_level <= level_next;
      result.rain_on <= (mode_next == dms_pkg::MODE_RAIN);
      result.ripples_on <= (mode_next == dms_pkg::MODE_RIPPLES);
      result.wind_value <= wind_next;
      result.status_changed <= step_mode || step_direction || step_level;
      result.help_requested <= help;
    end
  end

endmodule

// ===== rtl/dms_debounce.sv =====
module dms_debounce (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [dms_pkg::BUTTON_COUNT-1:0] raw,
  input  logic [dms_pkg::COUNT_W-1:0]  debounce_ticks,
  output dms_pkg::press_t              press
);

  logic [dms_pkg::BUTTON_COUNT-1:0] last_raw;
  logic [dms_pkg::BUTTON_COUNT-1:0] stable;
  logic [dms_pkg::COUNT_W-1:0]      elapsed [dms_pkg::BUTTON_COUNT];

  logic [dms_pkg::BUTTON_COUNT-1:0] last_raw_next;
  logic [dms_pkg::BUTTON_COUNT-1:0] stable_next;
  logic [dms_pkg::COUNT_W-1:0]      elapsed_next [dms_pkg::BUTTON_COUNT];
  logic [dms_pkg::BUTTON_COUNT-1:0] fell;

  for (genvar k = 0; k < dms_pkg::BUTTON_COUNT; k++) begin : g_btn
    logic accept;

    always_comb begin
      // a raw change restarts the count, otherwise it saturates upward
      if (raw[k] != last_raw[k]) begin
        elapsed_next[k] = '0;
      end else if (&elapsed[k]) begin
        elapsed_next[k] = elapsed[k];
      end else begin
        elapsed_next[k] = elapsed[k] + 1'b1;
      end
    end

    assign accept = (elapsed_next[k] >= debounce_ticks) && (raw[k] != stable[k]);
    assign last_raw_next[k] = raw[k];
    assign stable_next[k] = accept ? raw[k] : stable[k];
    assign fell[k] = en && accept && !raw[k];

    always_ff @(posedge clk) begin
      if (rst) begin
        last_raw[k] <= 1'b1;
        stable[k] <= 1'b1;
        elapsed[k] <= '1;
      end else if (en) begin
        last_raw[k] <= last_raw_next[k];
        stable[k] <= stable_next[k];
        elapsed[k] <= elapsed_next[k];
      end
    end
  end

  assign press.rain = fell[dms_pkg::BTN_RAIN];
  assign press.direction = fell[dms_pkg::BTN_DIRECTION];
  assign press.intensity = fell[dms_pkg::BTN_INTENSITY];

endmodule
